/* rtl/core/retina_channel_dominance_color_map_top_defines.svh */
// Assertion helpers for the top-level RTL of the retina dominance color map.
`ifndef RETINA_CHANNEL_DOMINANCE_COLOR_MAP_TOP_DEFINES_SVH
`define RETINA_CHANNEL_DOMINANCE_COLOR_MAP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle
`define RCDCM_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("rcdcm same-cycle check failed");

// Check that a condition implies another in the next cycle
`define RCDCM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("rcdcm next-cycle check failed");

`else

`define RCDCM_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define RCDCM_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

/* rtl/core/rcdcm_pkg.sv */
`timescale 1ns / 1ps

package rcdcm_pkg;

  // Field widths
  localparam int RESP_W   = 9;
  localparam int MAG_BITS = 8;
  localparam int BYTE_W   = 8;
  localparam int CMP_W    = (MAG_BITS > RESP_W) ? MAG_BITS : RESP_W;
  localparam int IN_BITS  = 4 * RESP_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 10 * BYTE_W;

  localparam logic [CMP_W-1:0] MAG_MAX = CMP_W'((64'd1 << MAG_BITS) - 64'd1);

  typedef logic signed [RESP_W-1:0] resp_t;
  typedef logic [MAG_BITS-1:0]      mag_t;
  typedef logic [BYTE_W-1:0]        byte_t;

  // Winner of a dominance chain
  typedef enum logic [2:0] {
    SEL_ROD,
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE,
    SEL_BLACK
  } sel_t;

  typedef struct packed {
    resp_t blue;
    resp_t green;
    resp_t red;
    resp_t rod;
  } pixel_in_t;

  // Lowest member last: combined_red sits in the lowest byte
  typedef struct packed {
    byte_t rod_inverted;
    byte_t off_blue;
    byte_t off_green;
    byte_t off_red;
    byte_t on_blue;
    byte_t on_green;
    byte_t on_red;
    byte_t combined_blue;
    byte_t combined_green;
    byte_t combined_red;
  } result_t;

  typedef struct packed {
    byte_t blue;
    byte_t green;
    byte_t red;
  } rgb_t;

  // Absolute value saturated to MAG_MAX
  function automatic mag_t mag_of(resp_t x);
    logic [RESP_W-1:0] a;
    a = x[RESP_W-1] ? (~x + 1'b1) : x;
    if (CMP_W'(a) > MAG_MAX) begin
      return MAG_BITS'(MAG_MAX);
    end
    return MAG_BITS'(a);
  endfunction

  // Spread the winner's magnitude over the color bytes
  function automatic rgb_t put_pixel(sel_t sel, mag_t m);
    rgb_t  p;
    byte_t v;
    v = BYTE_W'(m);
    p.red   = (sel == SEL_ROD || sel == SEL_RED)   ? v : '0;
    p.green = (sel == SEL_ROD || sel == SEL_GREEN) ? v : '0;
    p.blue  = (sel == SEL_ROD || sel == SEL_BLUE)  ? v : '0;
    return p;
  endfunction

endpackage

/* rtl/core/retina_channel_dominance_color_map_top.sv */
`timescale 1ns / 1ps
`include "retina_channel_dominance_color_map_top_defines.svh"

// Retina dominance color map: one pixel of four signed ganglion responses
// (rod, red, green, blue cone) goes in, and one item comes out holding the
// combined dominance pixel, the on-channel pixel, the off-channel pixel and
// the inverted rod byte. The block takes one pixel per clock while in_tready
// is high. An accepted pixel passes through one input register, then the
// comparison and select logic, then the output register, which presents the
// result on out_tvalid; a low out_tready can hold it in either register.
// in_tready drops only while both registers are full and out_tready is low.

module retina_channel_dominance_color_map_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // rod_response[8:0], red_response[17:9], green_response[26:18],
  // blue_response[35:27], zero fill [39:36]
  input  logic [rcdcm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // combined_red[7:0], combined_green[15:8], combined_blue[23:16],
  // on_red[31:24], on_green[39:32], on_blue[47:40], off_red[55:48],
  // off_green[63:56], off_blue[71:64], rod_inverted[79:72]
  output logic [rcdcm_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                  s1_valid_r, s1_valid_nxt;
  rcdcm_pkg::pixel_in_t  s1_pix_r;
  logic                  out_valid_r, out_valid_nxt;
  rcdcm_pkg::result_t    out_res_r;
  rcdcm_pkg::result_t    res;
  logic                  s2_ready;
  logic                  in_fire;

  // Advance when the output register is empty or being drained
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;
  end

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= rcdcm_pkg::pixel_in_t'(in_tdata[rcdcm_pkg::IN_BITS-1:0]);
    end
  end

  rcdcm_core u_core (
    .pix_i (s1_pix_r),
    .res_o (res)
  );

  // Load the result register
  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  `RCDCM_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, s1_valid_r && !s2_ready, !in_tready)
  `RCDCM_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_tvalid && in_tready, s1_valid_r)
  `RCDCM_ASSERT_NEXT(a_stage_reaches_out, clk, rst_n, s1_valid_r && s2_ready, out_tvalid)
  `RCDCM_ASSERT_SAME(a_combined_shape, clk, rst_n, out_tvalid,
    ($countones({out_res_r.combined_red != '0, out_res_r.combined_green != '0,
                 out_res_r.combined_blue != '0}) <= 1) ||
    (out_res_r.combined_red == out_res_r.combined_green &&
     out_res_r.combined_green == out_res_r.combined_blue))

endmodule

/* rtl/core/rcdcm_core.sv */
`timescale 1ns / 1ps

module rcdcm_core (
  input  rcdcm_pkg::pixel_in_t pix_i,
  output rcdcm_pkg::result_t   res_o
);

  rcdcm_pkg::resp_t s0, s1, s2, s3;
  rcdcm_pkg::mag_t  m0, m1, m2, m3;
  rcdcm_pkg::sel_t  comb_sel, on_sel, off_sel;
  rcdcm_pkg::rgb_t  comb_px, on_px, off_px;

  // Signed responses and saturated magnitudes
  assign s0 = pix_i.rod;
  assign s1 = pix_i.red;
  assign s2 = pix_i.green;
  assign s3 = pix_i.blue;
  assign m0 = rcdcm_pkg::mag_of(s0);
  assign m1 = rcdcm_pkg::mag_of(s1);
  assign m2 = rcdcm_pkg::mag_of(s2);
  assign m3 = rcdcm_pkg::mag_of(s3);

  // Pick the magnitude of a chain's winner, zero for black
  function automatic rcdcm_pkg::mag_t pick(rcdcm_pkg::sel_t sel, rcdcm_pkg::mag_t a,
                                           rcdcm_pkg::mag_t b, rcdcm_pkg::mag_t c,
                                           rcdcm_pkg::mag_t d);
    rcdcm_pkg::mag_t r;
    unique case (sel)
      rcdcm_pkg::SEL_ROD:   r = a;
      rcdcm_pkg::SEL_RED:   r = b;
      rcdcm_pkg::SEL_GREEN: r = c;
      rcdcm_pkg::SEL_BLUE:  r = d;
      default:              r = '0;
    endcase
    return r;
  endfunction

  // Combined: rod must strictly beat every cone, ties among cones go red then green
  always_comb begin
    priority if (m0 > m1 && m0 > m2 && m0 > m3) begin
      comb_sel = rcdcm_pkg::SEL_ROD;
    end else if (m1 >= m2 && m1 >= m3) begin
      comb_sel = rcdcm_pkg::SEL_RED;
    end else if (m2 >= m3) begin
      comb_sel = rcdcm_pkg::SEL_GREEN;
    end else begin
      comb_sel = rcdcm_pkg::SEL_BLUE;
    end
  end

  // On: largest signed value that is not negative
  always_comb begin
    priority if (s0 >= s1 && s0 >= s2 && s0 >= s3 && !s0[rcdcm_pkg::RESP_W-1]) begin
      on_sel = rcdcm_pkg::SEL_ROD;
    end else if (s1 >= s2 && s1 >= s3 && !s1[rcdcm_pkg::RESP_W-1]) begin
      on_sel = rcdcm_pkg::SEL_RED;
    end else if (s2 >= s3 && !s2[rcdcm_pkg::RESP_W-1]) begin
      on_sel = rcdcm_pkg::SEL_GREEN;
    end else if (!s3[rcdcm_pkg::RESP_W-1]) begin
      on_sel = rcdcm_pkg::SEL_BLUE;
    end else begin
      on_sel = rcdcm_pkg::SEL_BLACK;
    end
  end

  // Off: smallest signed value that is negative, ties go to the later channel
  always_comb begin
    priority if (s0 < s1 && s0 < s2 && s0 < s3 && s0[rcdcm_pkg::RESP_W-1]) begin
      off_sel = rcdcm_pkg::SEL_ROD;
    end else if (s1 < s2 && s1 < s3 && s1[rcdcm_pkg::RESP_W-1]) begin
      off_sel = rcdcm_pkg::SEL_RED;
    end else if (s2 < s3 && s2[rcdcm_pkg::RESP_W-1]) begin
      off_sel = rcdcm_pkg::SEL_GREEN;
    end else if (s3[rcdcm_pkg::RESP_W-1]) begin
      off_sel = rcdcm_pkg::SEL_BLUE;
    end else begin
      off_sel = rcdcm_pkg::SEL_BLACK;
    end
  end

  // Build the three pixels
  assign comb_px = rcdcm_pkg::put_pixel(comb_sel, pick(comb_sel, m0, m1, m2, m3));
  assign on_px   = rcdcm_pkg::put_pixel(on_sel, pick(on_sel, m0, m1, m2, m3));
  assign off_px  = rcdcm_pkg::put_pixel(off_sel, pick(off_sel, m0, m1, m2, m3));

  assign res_o.combined_red   = comb_px.red;
  assign res_o.combined_green = comb_px.green;
  assign res_o.combined_blue  = comb_px.blue;
  assign res_o.on_red         = on_px.red;
  assign res_o.on_green       = on_px.green;
  assign res_o.on_blue        = on_px.blue;
  assign res_o.off_red        = off_px.red;
  assign res_o.off_green      = off_px.green;
  assign res_o.off_blue       = off_px.blue;
  assign res_o.rod_inverted   =
    rcdcm_pkg::BYTE_W'(rcdcm_pkg::MAG_MAX - rcdcm_pkg::CMP_W'(m0));

endmodule

/* tb/sv/dominance_map_checker.sv */
`timescale 1ns / 1ps

module dominance_map_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // rod_response[8:0], red_response[17:9], green_response[26:18],
  // blue_response[35:27], zero fill [39:36]
  input  logic [rcdcm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // combined_red[7:0] up to rod_inverted[79:72], one byte per field
  input  logic [rcdcm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                mismatches,
  output int                                outstanding
);
  import rcdcm_pkg::*;

  localparam int SAT_LIMIT = (1 << MAG_BITS) - 1;
  localparam int NUM_BYTES = 10;

  // Field names, lowest byte first
  string field_name [NUM_BYTES] = '{
    "combined_red", "combined_green", "combined_blue",
    "on_red", "on_green", "on_blue",
    "off_red", "off_green", "off_blue",
    "rod_inverted"
  };

  result_t pixel_results_due [$];

  // Absolute value, clipped at the saturation limit
  function automatic mag_t clip_mag(resp_t v);
    int a;
    a = (v < 0) ? -int'(v) : int'(v);
    if (a > SAT_LIMIT) begin
      a = SAT_LIMIT;
    end
    return mag_t'(a);
  endfunction

  // Gray for the rod, own color for a cone, black otherwise
  function automatic rgb_t paint(sel_t pick, mag_t m);
    rgb_t  px;
    byte_t b;
    b  = byte_t'(m);
    px = '0;
    case (pick)
      SEL_ROD: begin
        px.red   = b;
        px.green = b;
        px.blue  = b;
      end
      SEL_RED:   px.red   = b;
      SEL_GREEN: px.green = b;
      SEL_BLUE:  px.blue  = b;
      default:   px = '0;
    endcase
    return px;
  endfunction

  // Work out the full result item for one pixel
  function automatic result_t map_pixel(pixel_in_t px);
    int      s [4];
    mag_t    m [4];
    sel_t    pick;
    mag_t    w;
    rgb_t    comb;
    rgb_t    on_px;
    rgb_t    off_px;
    result_t r;
    s[0] = px.rod;
    s[1] = px.red;
    s[2] = px.green;
    s[3] = px.blue;
    m[0] = clip_mag(px.rod);
    m[1] = clip_mag(px.red);
    m[2] = clip_mag(px.green);
    m[3] = clip_mag(px.blue);

    // Combined: rod needs a strict win, cone ties go red then green
    if (m[0] > m[1] && m[0] > m[2] && m[0] > m[3]) begin
      pick = SEL_ROD;
    end else if (m[1] >= m[2] && m[1] >= m[3]) begin
      pick = SEL_RED;
    end else if (m[2] >= m[3]) begin
      pick = SEL_GREEN;
    end else begin
      pick = SEL_BLUE;
    end
    comb = paint(pick, m[int'(pick)]);

    // On: largest signed value, admitted only if non-negative
    if (s[0] >= s[1] && s[0] >= s[2] && s[0] >= s[3] && s[0] >= 0) begin
      pick = SEL_ROD;
    end else if (s[1] >= s[2] && s[1] >= s[3] && s[1] >= 0) begin
      pick = SEL_RED;
    end else if (s[2] >= s[3] && s[2] >= 0) begin
      pick = SEL_GREEN;
    end else if (s[3] >= 0) begin
      pick = SEL_BLUE;
    end else begin
      pick = SEL_BLACK;
    end
    w     = (pick == SEL_BLACK) ? '0 : m[int'(pick)];
    on_px = paint(pick, w);

    // Off: strict-less chain, admitted only if negative
    if (s[0] < s[1] && s[0] < s[2] && s[0] < s[3] && s[0] < 0) begin
      pick = SEL_ROD;
    end else if (s[1] < s[2] && s[1] < s[3] && s[1] < 0) begin
      pick = SEL_RED;
    end else if (s[2] < s[3] && s[2] < 0) begin
      pick = SEL_GREEN;
    end else if (s[3] < 0) begin
      pick = SEL_BLUE;
    end else begin
      pick = SEL_BLACK;
    end
    w      = (pick == SEL_BLACK) ? '0 : m[int'(pick)];
    off_px = paint(pick, w);

    r.combined_red   = comb.red;
    r.combined_green = comb.green;
    r.combined_blue  = comb.blue;
    r.on_red         = on_px.red;
    r.on_green       = on_px.green;
    r.on_blue        = on_px.blue;
    r.off_red        = off_px.red;
    r.off_green      = off_px.green;
    r.off_blue       = off_px.blue;
    r.rod_inverted   = byte_t'(SAT_LIMIT - int'(m[0]));
    return r;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Queue a prediction per accepted pixel, compare each result item against the oldest
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pixel_results_due = {pixel_results_due,
                             map_pixel(pixel_in_t'(in_tdata[IN_BITS-1:0]))};
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (pixel_results_due.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = pixel_results_due.pop_front();
          for (int k = 0; k < NUM_BYTES; k++) begin
            if (got[k*8 +: 8] !== want[k*8 +: 8]) begin
              $display("%0t: %s expected %0d, got %0d", $time, field_name[k],
                       want[k*8 +: 8], got[k*8 +: 8]);
              mismatches++;
            end
          end
        end
      end
      outstanding = pixel_results_due.size();
    end
  end

endmodule

/* tb/sv/tb_retina_channel_dominance_color_map_top.sv */
`timescale 1ns / 1ps

module tb_retina_channel_dominance_color_map_top;
  import rcdcm_pkg::*;

  localparam int RANDOM_PIXELS = 1150;

  // Value mixes for random pixels
  typedef enum {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_CORNER,
    SPREAD_TIED
  } spread_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  bit steady = 1'b0;  // no idling on either side while set

  int corner_vals [8] = '{-256, -255, -254, -1, 0, 1, 254, 255};

  always #4 clk = ~clk;

  retina_channel_dominance_color_map_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dominance_map_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  // Offer one pixel after a random gap and hold it until accepted
  task automatic drive_pixel(input int rod, input int red, input int green, input int blue);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, resp_t'(blue), resp_t'(green),
                  resp_t'(red), resp_t'(rod)};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic int draw_resp(spread_t flavor, int shared);
    case (flavor)
      SPREAD_FULL:   return int'($urandom_range(0, 511)) - 256;
      SPREAD_NARROW: return int'($urandom_range(0, 10)) - 5;
      SPREAD_CORNER: return corner_vals[$urandom_range(0, 7)];
      default: begin
        case ($urandom_range(0, 3))
          0:       return shared;
          1:       return -shared;
          2:       return shared + 1;
          default: return int'($urandom_range(0, 511)) - 256;
        endcase
      end
    endcase
  endfunction

  // Draw a stall before each result item, then take it
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    spread_t flavor;
    int      shared;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes, ties, saturation at -256, each winner, black pixels
    drive_pixel(0, 0, 0, 0);
    drive_pixel(255, 255, 255, 255);
    drive_pixel(-256, -256, -256, -256);
    drive_pixel(-255, -255, -255, -255);
    drive_pixel(-255, -256, 255, 0);
    drive_pixel(-256, 255, 0, 0);
    drive_pixel(255, -256, 0, 0);
    drive_pixel(-256, 0, 0, 0);
    drive_pixel(100, 20, 30, 40);
    drive_pixel(-100, 20, 30, 40);
    drive_pixel(0, 50, 50, 50);
    drive_pixel(0, 10, 50, 50);
    drive_pixel(0, 10, 20, 50);
    drive_pixel(0, -50, -50, -50);
    drive_pixel(-1, -2, -3, -4);
    drive_pixel(-4, -3, -2, -1);
    drive_pixel(5, 6, 7, 8);
    drive_pixel(-10, 9, -5, -5);
    drive_pixel(-10, -5, 9, -5);
    drive_pixel(1, 1, 1, 1);
    drive_pixel(-256, -255, -256, -255);
    drive_pixel(1, -1, 1, -1);
    drive_pixel(-3, -3, -3, 2);

    // Random pixels in stretches of 100, each either with random gaps or at full rate
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_PIXELS / 2) begin
        // Hold off until every pending result item has drained
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      flavor = spread_t'($urandom_range(0, 3));
      shared = int'($urandom_range(0, 511)) - 256;
      drive_pixel(draw_resp(flavor, shared), draw_resp(flavor, shared),
                  draw_resp(flavor, shared), draw_resp(flavor, shared));
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain, then watch for stray results before the verdict
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** retina_channel_dominance_color_map_top: PASSED **");
    end else begin
      $display("** retina_channel_dominance_color_map_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** retina_channel_dominance_color_map_top: FAILED **");
    $finish;
  end

endmodule
